// File: rtl/xcfr_pkg.sv
// ----------------------------------------------------------------------------
// xcfr_pkg
// Types and codes shared by the command frame receiver and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package xcfr_pkg;

    // Field types
    typedef logic [7:0] byte_t;
    typedef logic [8:0] idx_t;
    typedef logic [1:0] req_t;
    typedef logic [2:0] status_t;

    // Receive event codes
    localparam req_t REQ_BYTE    = 2'd0;
    localparam req_t REQ_TIMEOUT = 2'd1;
    localparam req_t REQ_ERROR   = 2'd2;

    // Result status codes
    localparam status_t ST_BODY     = 3'd0;
    localparam status_t ST_GOOD     = 3'd1;
    localparam status_t ST_CSUM     = 3'd2;
    localparam status_t ST_SHORT    = 3'd3;
    localparam status_t ST_ABORT    = 3'd4;

    // Frame layout
    localparam byte_t START_BYTE_RESET = 8'hFF;
    localparam idx_t  FRAME_OVERHEAD   = 9'd4;
    localparam idx_t  MIN_FRAME_BYTES  = 9'd5;
    localparam idx_t  IDX_CMD          = 9'd1;
    localparam idx_t  IDX_LEN          = 9'd2;
    localparam idx_t  IDX_FIRST_END    = 9'd3;

endpackage : xcfr_pkg

`default_nettype wire

// File: rtl/xor_checked_command_frame_receiver.sv
// ----------------------------------------------------------------------------
// xor_checked_command_frame_receiver
// Deframes length-prefixed command frames from UART receive events and
// checks the XOR of each frame against its last byte.
// ----------------------------------------------------------------------------
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-------------------------------
//   in      | to block  | in_valid / in_stall   | req_type, rx_byte
//   out     | from block| out_valid / out_stall | out_byte, byte_index,
//           |           |                       | frame_cmd, status, last
//   config  | to block  | start_byte_we         | start_byte
//
// One item per cycle sustained while out_stall is low; each item passes
// through the input register followed by the result register.
// Reset clears the frame state to idle and sets the start byte to 0xFF.
// While out_stall holds the result register, the input register still takes
// one more beat; in_stall rises only when both registers are full.
// ----------------------------------------------------------------------------
`default_nettype none

module xor_checked_command_frame_receiver (
    input  wire logic              clk,
    input  wire logic              rst_n,
    // configuration
    input  wire logic              start_byte_we,
    input  wire xcfr_pkg::byte_t   start_byte,
    // receive events
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire xcfr_pkg::req_t    req_type,
    input  wire xcfr_pkg::byte_t   rx_byte,
    // frame bytes
    output logic                   out_valid,
    input  wire logic              out_stall,
    output xcfr_pkg::byte_t        out_byte,
    output xcfr_pkg::idx_t         byte_index,
    output xcfr_pkg::byte_t        frame_cmd,
    output xcfr_pkg::status_t      status,
    output logic                   last
);
    import xcfr_pkg::*;

    // configuration
    byte_t   start_reg;

    // input register
    logic    in_vld_reg, in_vld_next;
    req_t    in_req_reg;
    byte_t   in_byte_reg;

    // frame state
    idx_t    byte_count_reg, byte_count_next;
    idx_t    exp_len_reg, exp_len_next;
    byte_t   xor_reg, xor_next;
    byte_t   cmd_reg, cmd_next;

    // result register
    logic    out_vld_reg, out_vld_next;
    byte_t   out_byte_reg, out_byte_next;
    idx_t    out_idx_reg, out_idx_next;
    byte_t   out_cmd_reg, out_cmd_next;
    status_t out_st_reg, out_st_next;
    logic    out_last_reg, out_last_next;

    logic    advance;
    logic    accept;
    logic    frame_idle;
    logic    frame_end;
    byte_t   cmd_now;

    // Advance the input register into the result register when it can drain
    assign advance  = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !advance;
    assign accept   = in_valid && !in_stall;

    assign frame_idle = (byte_count_reg == '0);
    assign frame_end  = (byte_count_reg >= IDX_FIRST_END)
                     && ((byte_count_reg + 9'd1) == exp_len_reg);
    assign cmd_now    = (byte_count_reg == IDX_CMD) ? in_byte_reg : cmd_reg;

    // Hold the start byte until the next write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= START_BYTE_RESET;
        end
        else if (start_byte_we)
        begin
            start_reg <= start_byte;
        end
    end

    // Capture each accepted beat
    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (accept)
        begin
            in_vld_next = 1'b1;
        end
        else if (advance)
        begin
            in_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_req_reg  <= req_type;
            in_byte_reg <= rx_byte;
        end
    end

    // Deframe: update the frame state and form at most one result
    always_comb
    begin
        byte_count_next = byte_count_reg;
        exp_len_next    = exp_len_reg;
        xor_next        = xor_reg;
        cmd_next        = cmd_reg;
        out_byte_next   = out_byte_reg;
        out_idx_next    = out_idx_reg;
        out_cmd_next    = out_cmd_reg;
        out_st_next     = out_st_reg;
        out_last_next   = out_last_reg;
        out_vld_next    = out_vld_reg && out_stall;

        if (advance)
        begin
            out_vld_next = 1'b0;
            priority if (in_req_reg == REQ_TIMEOUT || in_req_reg == REQ_ERROR)
            begin
                // abort a partial frame; ignore while idle
                if (!frame_idle)
                begin
                    out_vld_next    = 1'b1;
                    out_byte_next   = '0;
                    out_idx_next    = byte_count_reg;
                    out_cmd_next    = cmd_reg;
                    out_st_next     = ST_ABORT;
                    out_last_next   = 1'b1;
                    byte_count_next = '0;
                    exp_len_next    = '0;
                    xor_next        = '0;
                    cmd_next        = '0;
                end
            end
            else if (in_req_reg == REQ_BYTE && frame_idle)
            begin
                // drop bytes until the start byte opens a frame
                if (in_byte_reg == start_reg)
                begin
                    out_vld_next    = 1'b1;
                    out_byte_next   = in_byte_reg;
                    out_idx_next    = '0;
                    out_cmd_next    = '0;
                    out_st_next     = ST_BODY;
                    out_last_next   = 1'b0;
                    byte_count_next = 9'd1;
                    exp_len_next    = '0;
                    xor_next        = in_byte_reg;
                    cmd_next        = '0;
                end
            end
            else if (in_req_reg == REQ_BYTE && frame_end)
            begin
                // close the frame and report its status
                out_vld_next  = 1'b1;
                out_byte_next = in_byte_reg;
                out_idx_next  = byte_count_reg;
                out_cmd_next  = cmd_reg;
                out_last_next = 1'b1;
                if (xor_reg != in_byte_reg)
                begin
                    out_st_next = ST_CSUM;
                end
                else if (exp_len_reg < MIN_FRAME_BYTES)
                begin
                    out_st_next = ST_SHORT;
                end
                else
                begin
                    out_st_next = ST_GOOD;
                end
                byte_count_next = '0;
                exp_len_next    = '0;
                xor_next        = '0;
                cmd_next        = '0;
            end
            else if (in_req_reg == REQ_BYTE)
            begin
                // pass a body byte and advance the count
                out_vld_next    = 1'b1;
                out_byte_next   = in_byte_reg;
                out_idx_next    = byte_count_reg;
                out_cmd_next    = cmd_now;
                out_st_next     = ST_BODY;
                out_last_next   = 1'b0;
                cmd_next        = cmd_now;
                xor_next        = xor_reg ^ in_byte_reg;
                byte_count_next = byte_count_reg + 9'd1;
                if (byte_count_reg == IDX_LEN)
                begin
                    exp_len_next = {1'b0, in_byte_reg} + FRAME_OVERHEAD;
                end
            end
            else
            begin
                // unused event code: drop
                out_vld_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            exp_len_reg    <= '0;
            xor_reg        <= '0;
            cmd_reg        <= '0;
            out_vld_reg    <= 1'b0;
        end
        else
        begin
            byte_count_reg <= byte_count_next;
            exp_len_reg    <= exp_len_next;
            xor_reg        <= xor_next;
            cmd_reg        <= cmd_next;
            out_vld_reg    <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_idx_reg  <= out_idx_next;
        out_cmd_reg  <= out_cmd_next;
        out_st_reg   <= out_st_next;
        out_last_reg <= out_last_next;
    end

    // Drive the result beat
    assign out_valid  = out_vld_reg;
    assign out_byte   = out_byte_reg;
    assign byte_index = out_idx_reg;
    assign frame_cmd  = out_cmd_reg;
    assign status     = out_st_reg;
    assign last       = out_last_reg;

endmodule : xor_checked_command_frame_receiver

`default_nettype wire

// File: rtl/xcfr_checker.sv
// ----------------------------------------------------------------------------
// xcfr_checker
// Port-level checks on the result beats of the command frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module xcfr_checker (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                out_valid,
    input  wire logic                out_stall,
    input  wire xcfr_pkg::byte_t     out_byte,
    input  wire xcfr_pkg::idx_t      byte_index,
    input  wire xcfr_pkg::byte_t     frame_cmd,
    input  wire xcfr_pkg::status_t   status,
    input  wire logic                last
);
    import xcfr_pkg::*;

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte)
            && $stable(byte_index) && $stable(status) && $stable(last))
        else $error("stalled result beat changed");

    // Mark the frame end exactly on a non-body status
    a_last_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last == (status != ST_BODY)))
        else $error("last does not match status");

    // Zero the byte of an aborted frame
    a_abort_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_ABORT |-> out_byte == '0)
        else $error("abort beat carries a byte");

    // Open each frame with a body beat that has no command yet
    a_first_beat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_index == '0 |-> frame_cmd == '0 && !last)
        else $error("first frame beat malformed");

    // Close a frame by its checksum byte no earlier than the fourth byte
    a_end_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last && status != ST_ABORT |-> byte_index >= IDX_FIRST_END)
        else $error("frame closed too early");

endmodule : xcfr_checker

bind xor_checked_command_frame_receiver xcfr_checker u_xcfr_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .byte_index (byte_index),
    .frame_cmd  (frame_cmd),
    .status     (status),
    .last       (last)
);

`default_nettype wire
